[rtl/fqsa_pkg.sv]
// ----------------------------------------------------------------------------
// fqsa_pkg
// Shared types and constants for the round-robin fair queue source arbiter.
// ----------------------------------------------------------------------------
package fqsa_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int SRC_W  = $clog2(NUM_SOURCES);
	localparam int CNT_W  = $clog2(NUM_SOURCES + 1);
	localparam logic [CNT_W-1:0] UNATTACHED = CNT_W'(NUM_SOURCES);

	typedef enum logic [2:0] {
		CMD_ATTACH     = 3'd0,
		CMD_ACTIVATE   = 3'd1,
		CMD_DEACTIVATE = 3'd2,
		CMD_TERMINATE  = 3'd3,
		CMD_RECEIVE    = 3'd4,
		CMD_QUERY      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FRAME   = 2'd1,
		ST_NONE    = 2'd2,
		ST_ABORT   = 2'd3
	} status_t;

	// Swap request from sequencer to table unit.
	typedef struct packed {
		logic             go;
		logic [SRC_W-1:0] slot_a;
		logic [SRC_W-1:0] slot_b;
	} swap_req_t;

	// Table unit write port used for attach / erase.
	typedef struct packed {
		logic             ord_we;
		logic [SRC_W-1:0] ord_addr;
		logic [SRC_W-1:0] ord_data;
		logic             sos_we;
		logic [SRC_W-1:0] sos_addr;
		logic [CNT_W-1:0] sos_data;
	} tbl_wr_t;

endpackage

[rtl/fqsa_tables.sv]
// ----------------------------------------------------------------------------
// fqsa_tables
// Ordering table (memory, registered read) and slot-of-source map with
// per-entry valid bits. Performs slot swaps and direct writes.
// ----------------------------------------------------------------------------
module fqsa_tables (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fqsa_pkg::SRC_W-1:0]        ord_raddr,
	output logic [fqsa_pkg::SRC_W-1:0]        ord_rdata,
	input  logic [fqsa_pkg::SRC_W-1:0]        sos_raddr,
	output logic [fqsa_pkg::CNT_W-1:0]        sos_rdata,
	input  fqsa_pkg::swap_req_t               swap,
	input  fqsa_pkg::tbl_wr_t                 wr
);

	logic [fqsa_pkg::SRC_W-1:0] ord_mem [fqsa_pkg::NUM_SOURCES];
	logic [fqsa_pkg::CNT_W-1:0] sos_mem [fqsa_pkg::NUM_SOURCES];
	logic [fqsa_pkg::NUM_SOURCES-1:0] sos_vld_q;
	logic [fqsa_pkg::SRC_W-1:0] sa, sb;

	assign sa = ord_mem[swap.slot_a];
	assign sb = ord_mem[swap.slot_b];

	// Read ports, registered.
	always_ff @(posedge clk) begin
		ord_rdata <= ord_mem[ord_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sos_rdata <= fqsa_pkg::UNATTACHED;
		end else begin
			sos_rdata <= sos_vld_q[sos_raddr] ? sos_mem[sos_raddr] : fqsa_pkg::UNATTACHED;
		end
	end

	// Swap two slots or apply a direct write.
	always_ff @(posedge clk) begin
		if (swap.go) begin
			ord_mem[swap.slot_a] <= sb;
			ord_mem[swap.slot_b] <= sa;
			sos_mem[sa] <= fqsa_pkg::CNT_W'(swap.slot_b);
			sos_mem[sb] <= fqsa_pkg::CNT_W'(swap.slot_a);
		end else begin
			if (wr.ord_we) ord_mem[wr.ord_addr] <= wr.ord_data;
			if (wr.sos_we) sos_mem[wr.sos_addr] <= wr.sos_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sos_vld_q <= '0;
		end else if (!swap.go && wr.sos_we) begin
			sos_vld_q[wr.sos_addr] <= 1'b1;
		end
	end

endmodule

[rtl/fair_queue_source_arbiter.sv]
// ----------------------------------------------------------------------------
// fair_queue_source_arbiter
// Round-robin fair queue over attached sources with an active prefix.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / ready | cmd, source, ready_mask, more_mask
// out     | output    | valid / ready | status, served_source, frame_more, has_data
//
// One request at a time. Receive and query inspect one source per ordering-table
// read, up to NUM_SOURCES sources; an abort or an immediate query answer skips the
// scan and replies at once.
// Reset clears all counters and marks every source unattached at once.
// The result is held in an output register until accepted; the next
// request is taken in the cycle after that.
// ----------------------------------------------------------------------------
module fair_queue_source_arbiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    cmd,
	input  logic [fqsa_pkg::SRC_W-1:0]    source,
	input  logic [fqsa_pkg::NUM_SOURCES-1:0] ready_mask,
	input  logic [fqsa_pkg::NUM_SOURCES-1:0] more_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [fqsa_pkg::SRC_W-1:0]    served_source,
	output logic                          frame_more,
	output logic                          has_data
);

	localparam int SW = fqsa_pkg::SRC_W;
	localparam int CW = fqsa_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ATT, S_SOS, S_ACT, S_DEACT, S_T_CUR, S_T_CUR2, S_T_SLOT,
		S_T_POS, S_T_POS2, S_T_FIN, S_SCAN, S_SCAN2, S_REPLY
	} state_t;

	state_t state_q, state_d;

	logic [2:0]    cmd_q;
	logic [SW-1:0] src_q;
	logic [fqsa_pkg::NUM_SOURCES-1:0] rdy_q, more_q;
	logic [CW-1:0] att_q, act_q, cur_q;
	logic          pin_q, abt_q;
	logic [CW-1:0] idx_q;
	logic          cval_q;
	logic [SW-1:0] csrc_q;

	logic [CW-1:0] att_d, act_d, cur_d, idx_d;
	logic          pin_d, abt_d, cval_d;
	logic [SW-1:0] csrc_d;
	logic [1:0]    st_d;
	logic [SW-1:0] srv_d;
	logic          fm_d, hd_d, res_ld;

	logic [SW-1:0] ord_raddr, ord_rdata;
	logic [SW-1:0] sos_raddr;
	logic [CW-1:0] sos_rdata;
	fqsa_pkg::swap_req_t swap;
	fqsa_pkg::tbl_wr_t   wr;

	logic [CW-1:0] na, nc, am1;
	logic          take;

	fqsa_tables u_tables (
		.clk(clk), .arst_n(arst_n),
		.ord_raddr(ord_raddr), .ord_rdata(ord_rdata),
		.sos_raddr(sos_raddr), .sos_rdata(sos_rdata),
		.swap(swap), .wr(wr)
	);

	// Normalized active count and current slot.
	always_comb begin
		na = (act_q > att_q) ? att_q : act_q;
		nc = (na == '0 || cur_q >= na) ? '0 : cur_q;
	end

	assign in_ready = (state_q == S_IDLE);
	assign take = in_valid && in_ready;
	assign am1 = act_q - CW'(1);

	always_comb begin
		state_d = state_q;
		att_d = att_q; act_d = act_q; cur_d = cur_q;
		pin_d = pin_q; abt_d = abt_q; idx_d = idx_q;
		cval_d = cval_q; csrc_d = csrc_q;
		st_d = fqsa_pkg::ST_DONE; srv_d = '0; fm_d = 1'b0; hd_d = 1'b0;
		res_ld = 1'b0;
		ord_raddr = cur_q[SW-1:0];
		sos_raddr = src_q;
		swap = '0;
		wr = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					sos_raddr = source;
					ord_raddr = nc[SW-1:0];
					// Normalize for known commands other than attach.
					if (cmd inside {[fqsa_pkg::CMD_ACTIVATE:fqsa_pkg::CMD_QUERY]}) begin
						act_d = na; cur_d = nc;
						if (na == '0) pin_d = 1'b0;
					end
					case (cmd)
						fqsa_pkg::CMD_ATTACH:     state_d = S_ATT;
						fqsa_pkg::CMD_ACTIVATE:   state_d = S_ACT;
						fqsa_pkg::CMD_DEACTIVATE: state_d = S_DEACT;
						fqsa_pkg::CMD_TERMINATE:  state_d = S_T_CUR;
						fqsa_pkg::CMD_RECEIVE: begin
							if (abt_q) begin
								abt_d = 1'b0; st_d = fqsa_pkg::ST_ABORT;
								res_ld = 1'b1; state_d = S_REPLY;
							end else state_d = S_SCAN;
						end
						fqsa_pkg::CMD_QUERY: begin
							if (abt_q || (pin_q && na != '0)) begin
								hd_d = 1'b1; res_ld = 1'b1; state_d = S_REPLY;
							end else state_d = S_SCAN;
						end
						default: begin
							res_ld = 1'b1; state_d = S_REPLY;
						end
					endcase
				end
			end
			// Append source, then swap it into the active prefix.
			S_ATT: begin
				if (sos_rdata == fqsa_pkg::UNATTACHED && att_q < CW'(fqsa_pkg::NUM_SOURCES)) begin
					wr.ord_we = 1'b1; wr.ord_addr = att_q[SW-1:0]; wr.ord_data = src_q;
					wr.sos_we = 1'b1; wr.sos_addr = src_q; wr.sos_data = att_q;
					att_d = att_q + CW'(1);
					state_d = S_SOS;
				end else begin
					res_ld = 1'b1; state_d = S_REPLY;
				end
			end
			S_SOS: begin
				swap.go = 1'b1; swap.slot_a = act_q[SW-1:0];
				swap.slot_b = am1[SW-1:0] + SW'(0);
				swap.slot_b = SW'(att_q - CW'(1));
				act_d = act_q + CW'(1);
				res_ld = 1'b1; state_d = S_REPLY;
			end
			S_ACT: begin
				if (sos_rdata != fqsa_pkg::UNATTACHED && sos_rdata >= act_q) begin
					swap.go = 1'b1; swap.slot_a = sos_rdata[SW-1:0];
					swap.slot_b = act_q[SW-1:0];
					act_d = act_q + CW'(1);
				end
				res_ld = 1'b1; state_d = S_REPLY;
			end
			S_DEACT: begin
				if (sos_rdata != fqsa_pkg::UNATTACHED && sos_rdata < act_q) begin
					swap.go = 1'b1; swap.slot_a = sos_rdata[SW-1:0];
					swap.slot_b = am1[SW-1:0];
					act_d = am1;
					if (cur_q == am1) cur_d = '0;
				end
				res_ld = 1'b1; state_d = S_REPLY;
			end
			// Terminate: capture current source and slot of the target.
			S_T_CUR: begin
				idx_d = sos_rdata;
				cval_d = (act_q != '0) && (cur_q < act_q);
				csrc_d = ord_rdata;
				if (sos_rdata == fqsa_pkg::UNATTACHED) begin
					res_ld = 1'b1; state_d = S_REPLY;
				end else begin
					if (pin_q && cval_d && ord_rdata == src_q) begin
						pin_d = 1'b0; abt_d = 1'b1;
					end
					state_d = S_T_SLOT;
				end
			end
			S_T_SLOT: begin
				if (idx_q < act_q) begin
					swap.go = 1'b1; swap.slot_a = idx_q[SW-1:0];
					swap.slot_b = am1[SW-1:0];
					act_d = am1;
					if (cur_q == am1) cur_d = '0;
				end
				state_d = S_T_POS;
			end
			S_T_POS: begin
				sos_raddr = src_q;
				state_d = S_T_POS2;
			end
			S_T_POS2: begin
				swap.go = 1'b1; swap.slot_a = sos_rdata[SW-1:0];
				swap.slot_b = SW'(att_q - CW'(1));
				att_d = att_q - CW'(1);
				if (act_q > att_d) act_d = att_d;
				sos_raddr = csrc_q;
				state_d = S_T_CUR2;
			end
			S_T_CUR2: begin
				wr.sos_we = 1'b1; wr.sos_addr = src_q; wr.sos_data = fqsa_pkg::UNATTACHED;
				sos_raddr = csrc_q;
				if (act_q == '0) begin
					cur_d = '0; pin_d = 1'b0;
				end else if (cur_q >= act_q) cur_d = '0;
				state_d = S_T_FIN;
			end
			S_T_FIN: begin
				if (cval_q && csrc_q != src_q) begin
					if (sos_rdata < act_q) cur_d = sos_rdata;
				end else if (act_q != '0) begin
					cur_d = (idx_q < act_q) ? idx_q : '0;
				end
				res_ld = 1'b1; state_d = S_REPLY;
			end
			// Scan: order entry at cur_q arrives in the cycle after its read.
			S_SCAN: begin
				if (act_q == '0) begin
					st_d = (cmd_q == fqsa_pkg::CMD_RECEIVE) ? fqsa_pkg::ST_NONE
						: fqsa_pkg::ST_DONE;
					res_ld = 1'b1; state_d = S_REPLY;
				end else begin
					ord_raddr = cur_q[SW-1:0];
					state_d = S_SCAN2;
				end
			end
			S_SCAN2: begin
				if (rdy_q[ord_rdata]) begin
					if (cmd_q == fqsa_pkg::CMD_RECEIVE) begin
						pin_d = more_q[ord_rdata];
						if (!more_q[ord_rdata])
							cur_d = (cur_q + CW'(1) == act_q) ? '0 : cur_q + CW'(1);
						st_d = fqsa_pkg::ST_FRAME; srv_d = ord_rdata;
						fm_d = more_q[ord_rdata];
					end else hd_d = 1'b1;
					res_ld = 1'b1; state_d = S_REPLY;
				end else begin
					swap.go = 1'b1; swap.slot_a = cur_q[SW-1:0];
					swap.slot_b = am1[SW-1:0];
					act_d = am1;
					if (cur_q == am1) cur_d = '0;
					if (pin_q && cmd_q == fqsa_pkg::CMD_RECEIVE) begin
						pin_d = 1'b0; st_d = fqsa_pkg::ST_ABORT;
						res_ld = 1'b1; state_d = S_REPLY;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_REPLY: begin
				if (!out_valid || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			att_q <= '0; act_q <= '0; cur_q <= '0;
			pin_q <= 1'b0; abt_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			att_q <= att_d; act_q <= act_d; cur_q <= cur_d;
			pin_q <= pin_d; abt_q <= abt_d;
			if (res_ld) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Latch request payload and scratch values.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd; src_q <= source; rdy_q <= ready_mask; more_q <= more_mask;
		end
		idx_q <= idx_d; cval_q <= cval_d; csrc_q <= csrc_d;
		if (res_ld) begin
			status <= st_d; served_source <= srv_d; frame_more <= fm_d; has_data <= hd_d;
		end
	end

endmodule
